// ===== rtl/mas_pkg.sv =====
// Shared types, register indexes and constants of the Metropolis accept step unit.
package mas_pkg;

  // Register indexes of the configuration port
  typedef enum logic [1:0] {
    CFG_INVERSE_KT     = 2'd0,
    CFG_TRACK_BEST     = 2'd1,
    CFG_STOP_THRESHOLD = 2'd2
  } cfg_idx_t;

  // Input request: start or proposal
  typedef struct packed {
    logic               opcode;
    logic signed [31:0] new_energy;
    logic        [31:0] move_ratio;
    logic        [31:0] uniform_random;
  } in_t;

  // Result of one request
  typedef struct packed {
    logic               accepted;
    logic               was_downhill;
    logic               new_best;
    logic signed [31:0] current_energy;
    logic signed [31:0] best_energy_out;
    logic        [31:0] downhill_count;
    logic        [31:0] uphill_count;
    logic        [31:0] reject_count;
    logic               below_threshold;
  } out_t;

  // Opcode values
  localparam logic OP_START    = 1'b0;
  localparam logic OP_PROPOSAL = 1'b1;

  // Fixed-point constants, Q32 fractions
  localparam logic [63:0] ONE_Q32  = 64'd4294967296;
  localparam logic [63:0] LN2_Q32  = 64'd2977044472;
  // log2(e) in Q32 minus its integer one; the one is added back as a shift
  localparam logic [31:0] LOG2E_FRAC_Q32 = 32'd1901360723;
  localparam int unsigned TAYLOR_TERMS = 24;

  // Reset values of the configuration and the chain state
  localparam logic [31:0] INVERSE_KT_RESET     = 32'h0001_0000;
  localparam logic        TRACK_BEST_RESET     = 1'b1;
  localparam logic [31:0] STOP_THRESHOLD_RESET = 32'h8000_0000;
  localparam logic [31:0] BEST_ENERGY_RESET    = 32'h7FFF_FFFF;

  // Increment a counter that sticks at its maximum
  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    return (c == '1) ? c : c + 32'd1;
  endfunction

endpackage

// ===== rtl/mas_mul.sv =====
// Shared 32x32 unsigned multiplier with a registered product.
module mas_mul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] op_a,
  input  logic [31:0] op_b,
  output logic [63:0] prod_r
);

  // Capture the product when the sequencer issues an operation
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= 64'(op_a) * 64'(op_b);
    end
  end

endmodule

// ===== rtl/mas_exp_rom.sv =====
// Constant table of exp(-t) over one octave, Q1.32 with 2^32 as one, registered read.
module mas_exp_rom import mas_pkg::*; #(
  parameter int ENTRIES = 256,
  parameter int AW      = 8
) (
  input  logic          clk,
  input  logic [AW-1:0] addr,
  output logic [32:0]   data_r
);

  // Taylor series of exp(-t), t = k*ln2/ENTRIES, truncating each term
  function automatic logic [32:0] exp_entry(input int unsigned k);
    logic [63:0] t;
    logic [63:0] sum;
    logic [63:0] term;
    t    = (64'(k) * LN2_Q32) / ENTRIES;
    sum  = ONE_Q32;
    term = ONE_Q32;
    for (int unsigned n = 1; n <= TAYLOR_TERMS; n++) begin
      term = ((term * t) >> 32) / 64'(n);
      if (n[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum[32:0];
  endfunction

  logic [32:0] rom_w [ENTRIES];

  // Fill the table at elaboration
  for (genvar g = 0; g < ENTRIES; g++) begin : g_rom
    assign rom_w[g] = exp_entry(g);
  end

  // Register the read
  always_ff @(posedge clk) begin
    data_r <= rom_w[addr];
  end

endmodule

// ===== rtl/metropolis_accept_step_unit.sv =====
// Top level: Metropolis-Hastings accept/reject sequencer around a shared multiplier.
// A start request loads the initial energy and clears the counters; a proposal is
// judged against the current energy. Start and downhill requests pass from idle through
// the decision state to the commit state, which fills the output register; an uphill
// request walks one shared 32x32 multiplier through four products (energy step times
// inverse temperature, base change to log2, table index, factor times proposal ratio)
// plus a table read, and is rejected early when the exponent flushes the factor to
// zero. The next request is taken as soon as the sequencer is back in idle, while the
// previous result may still wait in the output register.
// Configuration writes are taken in every cycle and must come only while idle.
module metropolis_accept_step_unit import mas_pkg::*; #(
  parameter int EXP_TABLE_ENTRIES = 256,
  parameter int ENERGY_BITS       = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int EW = (ENERGY_BITS < 32) ? ENERGY_BITS : 32;
  localparam int SH = 32 - EW;
  localparam int KW = $clog2(EXP_TABLE_ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE, S_EVAL, S_M1, S_M2, S_M3, S_TAB, S_M4, S_CMP, S_FIN
  } state_t;

  typedef enum logic [1:0] {
    DEC_START, DEC_DOWN, DEC_UP, DEC_REJ
  } dec_t;

  state_t             state_r;
  dec_t               dec_r;
  logic               op_r;
  logic signed [31:0] enew_r;
  logic        [31:0] ratio_r;
  logic        [31:0] rnd_r;
  logic        [31:0] d_r;
  logic        [28:0] ahi_r;
  logic        [4:0]  ip_r;
  logic               e32_r;

  logic        [31:0] ikt_r;
  logic               trk_r;
  logic signed [31:0] thr_r;
  logic signed [31:0] last_r;
  logic signed [31:0] best_r;
  logic        [31:0] dcnt_r;
  logic        [31:0] ucnt_r;
  logic        [31:0] rcnt_r;

  out_t               out_r;
  logic               out_valid_r;

  logic signed [31:0] enew_shl;
  logic signed [31:0] enew_ext;
  logic               mul_en;
  logic        [31:0] mul_a;
  logic        [31:0] mul_b;
  logic        [63:0] prod_r;
  logic        [63:0] log_sum;
  logic        [32:0] rom_q;
  logic        [32:0] e_sh;
  logic        [63:0] cmp_lhs;
  logic        [63:0] cmp_rhs;
  logic               fin_fire;

  logic signed [31:0] last_nxt;
  logic signed [31:0] best_nxt;
  logic        [31:0] dcnt_nxt;
  logic        [31:0] ucnt_nxt;
  logic        [31:0] rcnt_nxt;
  logic               acc_nxt;
  logic               down_nxt;
  logic               nb_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Sign-extend the incoming energy from the configured energy width
  assign enew_shl = in_data.new_energy <<< SH;
  assign enew_ext = enew_shl >>> SH;

  // Base change sum: (a>>8)*log2(e) = ((a>>8)<<32) + (a>>8)*frac, then >>24
  assign log_sum = {3'b000, ahi_r, 32'b0} + prod_r;

  // Scale the table value by the integer part of the exponent
  assign e_sh = rom_q >> ip_r;

  // Final test: factor times ratio against the random number, Q16.48
  assign cmp_lhs = e32_r ? {ratio_r, 32'b0} : prod_r;
  assign cmp_rhs = {16'b0, rnd_r, 16'b0};

  assign fin_fire = (state_r == S_FIN) && (!out_valid_r || out_ready);

  // Select the multiplier operands for each step
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_r)
      S_M1: begin
        mul_en = 1'b1;
        mul_a  = d_r;
        mul_b  = ikt_r;
      end
      S_M2: begin
        mul_en = 1'b1;
        mul_a  = {3'b000, prod_r[36:8]};
        mul_b  = LOG2E_FRAC_Q32;
      end
      S_M3: begin
        mul_en = 1'b1;
        mul_a  = log_sum[55:24];
        mul_b  = 32'(EXP_TABLE_ENTRIES);
      end
      S_M4: begin
        mul_en = 1'b1;
        mul_a  = e_sh[31:0];
        mul_b  = ratio_r;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  mas_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  mas_exp_rom #(
    .ENTRIES (EXP_TABLE_ENTRIES),
    .AW      (KW)
  ) u_rom (
    .clk    (clk),
    .addr   (prod_r[32 +: KW]),
    .data_r (rom_q)
  );

  // Form the chain state after the decided outcome
  always_comb begin
    last_nxt = last_r;
    best_nxt = best_r;
    dcnt_nxt = dcnt_r;
    ucnt_nxt = ucnt_r;
    rcnt_nxt = rcnt_r;
    acc_nxt  = 1'b0;
    down_nxt = 1'b0;
    nb_nxt   = 1'b0;
    unique case (dec_r)
      DEC_START: begin
        last_nxt = enew_r;
        if (trk_r) begin
          best_nxt = enew_r;
          nb_nxt   = 1'b1;
        end
        dcnt_nxt = '0;
        ucnt_nxt = '0;
        rcnt_nxt = '0;
        acc_nxt  = 1'b1;
      end
      DEC_DOWN: begin
        acc_nxt  = 1'b1;
        down_nxt = 1'b1;
        dcnt_nxt = sat_inc(dcnt_r);
        if (trk_r && (enew_r < best_r)) begin
          best_nxt = enew_r;
          nb_nxt   = 1'b1;
        end
        last_nxt = enew_r;
      end
      DEC_UP: begin
        acc_nxt  = 1'b1;
        ucnt_nxt = sat_inc(ucnt_r);
        last_nxt = enew_r;
      end
      DEC_REJ: begin
        rcnt_nxt = sat_inc(rcnt_r);
      end
      default: begin
        acc_nxt = 1'b0;
      end
    endcase
  end

  // Sequencer, configuration and chain state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ikt_r       <= INVERSE_KT_RESET;
      trk_r       <= TRACK_BEST_RESET;
      thr_r       <= STOP_THRESHOLD_RESET;
      last_r      <= '0;
      best_r      <= BEST_ENERGY_RESET;
      dcnt_r      <= '0;
      ucnt_r      <= '0;
      rcnt_r      <= '0;
    end else begin
      // Write a configuration register; drop indexes beyond the list
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_INVERSE_KT:     ikt_r <= cfg_data;
          CFG_TRACK_BEST:     trk_r <= cfg_data[0];
          CFG_STOP_THRESHOLD: thr_r <= cfg_data;
          default:            ikt_r <= ikt_r;
        endcase
      end

      // Release the output register once the result is taken, unless refilled now
      if (out_valid_r && out_ready && !fin_fire) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= in_data.opcode;
            enew_r  <= enew_ext;
            ratio_r <= in_data.move_ratio;
            rnd_r   <= in_data.uniform_random;
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (op_r == OP_START) begin
            dec_r   <= DEC_START;
            state_r <= S_FIN;
          end else if (enew_r < last_r) begin
            dec_r   <= DEC_DOWN;
            state_r <= S_FIN;
          end else begin
            d_r     <= 32'(enew_r - last_r);
            state_r <= S_M1;
          end
        end
        S_M1: begin
          state_r <= S_M2;
        end
        S_M2: begin
          // Flush to zero when the exponent reaches 32
          if (|prod_r[63:37]) begin
            dec_r   <= DEC_REJ;
            state_r <= S_FIN;
          end else begin
            ahi_r   <= prod_r[36:8];
            state_r <= S_M3;
          end
        end
        S_M3: begin
          // Flush to zero when the integer part of the log2 exponent reaches 32
          if (|log_sum[63:61]) begin
            dec_r   <= DEC_REJ;
            state_r <= S_FIN;
          end else begin
            ip_r    <= log_sum[60:56];
            state_r <= S_TAB;
          end
        end
        S_TAB: begin
          state_r <= S_M4;
        end
        S_M4: begin
          e32_r   <= e_sh[32];
          state_r <= S_CMP;
        end
        S_CMP: begin
          dec_r   <= (cmp_lhs > cmp_rhs) ? DEC_UP : DEC_REJ;
          state_r <= S_FIN;
        end
        S_FIN: begin
          // Hold until the output register is free, then commit
          if (!out_valid_r || out_ready) begin
            last_r <= last_nxt;
            best_r <= best_nxt;
            dcnt_r <= dcnt_nxt;
            ucnt_r <= ucnt_nxt;
            rcnt_r <= rcnt_nxt;
            out_r.accepted        <= acc_nxt;
            out_r.was_downhill    <= down_nxt;
            out_r.new_best        <= nb_nxt;
            out_r.current_energy  <= last_nxt;
            out_r.best_energy_out <= best_nxt;
            out_r.downhill_count  <= dcnt_nxt;
            out_r.uphill_count    <= ucnt_nxt;
            out_r.reject_count    <= rcnt_nxt;
            out_r.below_threshold <= (best_nxt < thr_r);
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // A start clears all three counters
  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fin_fire && (dec_r == DEC_START) |=> (dcnt_r == '0) && (ucnt_r == '0) && (rcnt_r == '0))
    else $error("counters not cleared by start");

  // A rejection keeps the current energy
  a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
    fin_fire && (dec_r == DEC_REJ) |=> $stable(last_r) && (state_r == S_IDLE))
    else $error("rejection changed current energy");

  // A downhill result is always an accepted one
  a_down_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.was_downhill |-> out_r.accepted)
    else $error("downhill result not accepted");

  // A new best is the state just moved to
  a_best_current: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.new_best |-> (out_r.best_energy_out == out_r.current_energy))
    else $error("new best differs from current energy");
`endif

endmodule
